// ===== rtl/ssp_pkg.sv =====
package ssp_pkg;

  localparam logic       FUNC_BYTE    = 1'b0;
  localparam logic       FUNC_TIMEOUT = 1'b1;

  localparam logic       KIND_PARAM  = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] SUM_GOOD    = 8'hFF;
  localparam logic [7:0] ID_RESET    = 8'd254;

  localparam logic [8:0] POS_ID          = 9'd2;
  localparam logic [8:0] POS_LENGTH      = 9'd3;
  localparam logic [8:0] POS_ERROR       = 9'd4;
  localparam logic [8:0] POS_PARAM0      = 9'd5;
  localparam logic [8:0] COUNT_RESET     = 9'd2;
  localparam logic [8:0] TARGET_RESET    = 9'd6;
  localparam logic [8:0] LENGTH_OVERHEAD = 9'd4;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_index;
    logic [7:0] param_byte;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic       timeout_flag;
    logic       length_error;
    logic       checksum_error;
    logic       id_mismatch;
  } result_t;

endpackage

// ===== rtl/ssp_parser.sv =====
module ssp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_en,
  input  ssp_pkg::item_t  item,
  input  logic [7:0]      expected_id,
  output logic            res_vld,
  output ssp_pkg::result_t res
);

  logic       synced_r, synced_nxt;
  logic       last_ff_r, last_ff_nxt;
  logic [8:0] count_r, count_nxt;
  logic [8:0] target_r, target_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] err_r, err_nxt;

  logic       is_ff;
  logic       emit_status;
  logic       is_timeout;
  logic [8:0] pos_next;

  always_comb begin
    synced_nxt  = synced_r;
    last_ff_nxt = last_ff_r;
    count_nxt   = count_r;
    target_nxt  = target_r;
    sum_nxt     = sum_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    err_nxt     = err_r;
    res_vld     = 1'b0;
    res         = '0;
    emit_status = 1'b0;
    is_timeout  = (item.func == ssp_pkg::FUNC_TIMEOUT);
    is_ff       = (item.rx_byte == ssp_pkg::SYNC_BYTE);
    pos_next    = count_r + 9'd1;

    if (is_timeout) begin
      emit_status = 1'b1;
    end else if (!synced_r) begin
      if (is_ff && last_ff_r) begin
        synced_nxt  = 1'b1;
        last_ff_nxt = 1'b0;
      end else begin
        last_ff_nxt = is_ff;
      end
    end else begin
      sum_nxt   = sum_r + item.rx_byte;
      count_nxt = pos_next;
      if (count_r == ssp_pkg::POS_ID) begin
        id_nxt = item.rx_byte;
      end else if (count_r == ssp_pkg::POS_LENGTH) begin
        len_nxt    = item.rx_byte;
        target_nxt = {1'b0, item.rx_byte} + ssp_pkg::LENGTH_OVERHEAD;
      end else if (count_r == ssp_pkg::POS_ERROR) begin
        err_nxt = item.rx_byte;
      end
      if (count_nxt >= target_nxt) begin
        emit_status = 1'b1;
      end else if (count_r >= ssp_pkg::POS_PARAM0) begin
        res_vld         = 1'b1;
        res.kind        = ssp_pkg::KIND_PARAM;
        res.param_index = 8'(count_r - ssp_pkg::POS_PARAM0);
        res.param_byte  = item.rx_byte;
      end
    end

    if (emit_status) begin
      res_vld            = 1'b1;
      res.kind           = ssp_pkg::KIND_STATUS;
      res.servo_id       = id_nxt;
      res.servo_error    = err_nxt;
      res.timeout_flag   = is_timeout;
      res.length_error   = (count_nxt != ({1'b0, len_nxt} + ssp_pkg::LENGTH_OVERHEAD));
      res.checksum_error = (sum_nxt != ssp_pkg::SUM_GOOD);
      res.id_mismatch    = (id_nxt != expected_id);
      synced_nxt         = 1'b0;
      last_ff_nxt        = 1'b0;
      count_nxt          = ssp_pkg::COUNT_RESET;
      target_nxt         = ssp_pkg::TARGET_RESET;
      sum_nxt            = '0;
      id_nxt             = '0;
      len_nxt            = '0;
      err_nxt            = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r  <= 1'b0;
      last_ff_r <= 1'b0;
      count_r   <= ssp_pkg::COUNT_RESET;
      target_r  <= ssp_pkg::TARGET_RESET;
      sum_r     <= '0;
      id_r      <= '0;
      len_r     <= '0;
      err_r     <= '0;
    end else if (item_en) begin
      synced_r  <= synced_nxt;
      last_ff_r <= last_ff_nxt;
      count_r   <= count_nxt;
      target_r  <= target_nxt;
      sum_r     <= sum_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// ===== rtl/servo_status_packet_receiver.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_func, in_rx_byte
// out      output     out_valid / out_ready  out_kind .. out_id_mismatch
// cfg      input      cfg_wr_en              cfg_wr_data (expected id)
//
// one transaction per cycle unless the output stalls: input register, one parser pass,
// result register; bytes with no result free the slot
// synchronous active-low reset clears parser state, expected id resets to 254
// a stalled result holds the result register; the input register still takes one
// transaction and then in_ready drops until the result is taken
module servo_status_packet_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_param_index,
  output logic [7:0] out_param_byte,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_servo_error,
  output logic       out_timeout_flag,
  output logic       out_length_error,
  output logic       out_checksum_error,
  output logic       out_id_mismatch,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic             in_vld_r;
  ssp_pkg::item_t   item_r;
  logic             out_vld_r;
  ssp_pkg::result_t res_r;
  logic [7:0]       exp_id_r;

  logic             advance;
  logic             res_vld;
  ssp_pkg::result_t res;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r <= ssp_pkg::ID_RESET;
    end else if (cfg_wr_en) begin
      exp_id_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func    <= in_func;
      item_r.rx_byte <= in_rx_byte;
    end
  end

  ssp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (advance),
    .item        (item_r),
    .expected_id (exp_id_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_vld;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_kind           = res_r.kind;
  assign out_param_index    = res_r.param_index;
  assign out_param_byte     = res_r.param_byte;
  assign out_servo_id       = res_r.servo_id;
  assign out_servo_error    = res_r.servo_error;
  assign out_timeout_flag   = res_r.timeout_flag;
  assign out_length_error   = res_r.length_error;
  assign out_checksum_error = res_r.checksum_error;
  assign out_id_mismatch    = res_r.id_mismatch;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input register empty but not ready");

  a_param_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.kind == ssp_pkg::KIND_PARAM) |->
      (res_r.servo_id == 8'd0 && res_r.servo_error == 8'd0 && !res_r.timeout_flag &&
       !res_r.length_error && !res_r.checksum_error && !res_r.id_mismatch))
    else $error("parameter result carries status fields");

  a_param_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.kind == ssp_pkg::KIND_PARAM) |-> (res_r.param_index <= 8'd252))
    else $error("parameter index out of range");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.kind == ssp_pkg::KIND_STATUS) |->
      (res_r.param_index == 8'd0 && res_r.param_byte == 8'd0))
    else $error("status result carries parameter fields");

endmodule

// ===== tb/servo_status_packet_receiver_tb.sv =====
module servo_status_packet_receiver_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_func;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_kind;
  logic [7:0] out_param_index;
  logic [7:0] out_param_byte;
  logic [7:0] out_servo_id;
  logic [7:0] out_servo_error;
  logic       out_timeout_flag;
  logic       out_length_error;
  logic       out_checksum_error;
  logic       out_id_mismatch;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  servo_status_packet_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_param_index    (out_param_index),
    .out_param_byte     (out_param_byte),
    .out_servo_id       (out_servo_id),
    .out_servo_error    (out_servo_error),
    .out_timeout_flag   (out_timeout_flag),
    .out_length_error   (out_length_error),
    .out_checksum_error (out_checksum_error),
    .out_id_mismatch    (out_id_mismatch),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  ssp_pkg::item_t   rx_stream[$];
  ssp_pkg::result_t parsed_q[$];
  ssp_pkg::item_t   cur_item;
  ssp_pkg::result_t want_res;
  int      rx_queued;
  int      rx_accepted;
  int      errors;
  int      cycles;
  int      idle_odds;
  int      in_gap;
  int      out_gap;

  // mirror of the packet parser
  logic       pm_synced;
  logic       pm_prev_ff;
  logic [8:0] pm_count;
  logic [8:0] pm_target;
  logic [7:0] pm_sum;
  logic [7:0] pm_id;
  logic [7:0] pm_len;
  logic [7:0] pm_err;
  logic [7:0] want_id;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_parser();
    pm_synced = 1'b0;
    pm_prev_ff = 1'b0;
    pm_count = ssp_pkg::COUNT_RESET;
    pm_target = ssp_pkg::TARGET_RESET;
    pm_sum = '0;
    pm_id = '0;
    pm_len = '0;
    pm_err = '0;
  endtask

  task automatic close_packet(input logic timed_out);
    ssp_pkg::result_t r;
    r = '0;
    r.kind = ssp_pkg::KIND_STATUS;
    r.servo_id = pm_id;
    r.servo_error = pm_err;
    r.timeout_flag = timed_out;
    r.length_error = (pm_count - ssp_pkg::COUNT_RESET) != ({1'b0, pm_len} + 9'd2);
    r.checksum_error = pm_sum != ssp_pkg::SUM_GOOD;
    r.id_mismatch = pm_id != want_id;
    parsed_q.push_back(r);
    clear_parser();
  endtask

  task automatic parse_rx_item(input ssp_pkg::item_t it);
    logic [8:0]       pos;
    logic [8:0]       idx;
    ssp_pkg::result_t r;
    if (it.func == ssp_pkg::FUNC_TIMEOUT) begin
      close_packet(1'b1);
    end else if (!pm_synced) begin
      if (it.rx_byte == ssp_pkg::SYNC_BYTE && pm_prev_ff) begin
        clear_parser();
        pm_synced = 1'b1;
      end else begin
        pm_prev_ff = (it.rx_byte == ssp_pkg::SYNC_BYTE);
      end
    end else begin
      pos = pm_count;
      pm_sum = pm_sum + it.rx_byte;
      pm_count = pm_count + 9'd1;
      case (pos)
        ssp_pkg::POS_ID: pm_id = it.rx_byte;
        ssp_pkg::POS_LENGTH: begin
          pm_len = it.rx_byte;
          pm_target = {1'b0, it.rx_byte} + ssp_pkg::LENGTH_OVERHEAD;
        end
        ssp_pkg::POS_ERROR: pm_err = it.rx_byte;
        default: ;
      endcase
      if (pm_count >= pm_target) begin
        close_packet(1'b0);
      end else if (pos >= ssp_pkg::POS_PARAM0) begin
        idx = pos - ssp_pkg::POS_PARAM0;
        r = '0;
        r.kind = ssp_pkg::KIND_PARAM;
        r.param_index = idx[7:0];
        r.param_byte = it.rx_byte;
        parsed_q.push_back(r);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 200)
        $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic queue_item(input logic func, input logic [7:0] b);
    ssp_pkg::item_t it;
    it.func = func;
    it.rx_byte = b;
    rx_stream.push_back(it);
    rx_queued++;
  endtask

  // cut < 0 sends the whole packet, otherwise only the first cut bytes
  task automatic queue_packet(input logic [7:0] id, input logic [7:0] len,
                              input logic [7:0] err, input bit bad_sum,
                              input bit alt_params, input int cut);
    logic [7:0] pkt[$];
    logic [7:0] sum;
    logic [7:0] p;
    pkt.push_back(ssp_pkg::SYNC_BYTE);
    pkt.push_back(ssp_pkg::SYNC_BYTE);
    pkt.push_back(id);
    pkt.push_back(len);
    sum = id + len;
    if (len != 0) begin
      pkt.push_back(err);
      sum = sum + err;
    end
    if (len > 1) begin
      for (int i = 0; i < len - 2; i++) begin
        if (alt_params) p = i[0] ? 8'hFF : 8'h00;
        else p = 8'($urandom_range(0, 255));
        pkt.push_back(p);
        sum = sum + p;
      end
      sum = ~sum;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      pkt.push_back(sum);
    end
    for (int i = 0; i < pkt.size() && (cut < 0 || i < cut); i++)
      queue_item(ssp_pkg::FUNC_BYTE, pkt[i]);
  endtask

  task automatic random_phase(input int budget);
    int         stop;
    int         pick;
    int         len;
    int         n;
    logic [7:0] id;
    logic [7:0] err;
    logic [7:0] b;
    stop = rx_queued + budget;
    while (rx_queued < stop) begin
      pick = $urandom_range(0, 99);
      id = want_id;
      if ($urandom_range(0, 3) == 0) id = 8'($urandom_range(0, 255));
      err = 8'h00;
      if ($urandom_range(0, 1) == 0) err = 8'($urandom_range(0, 255));
      len = $urandom_range(0, 99);
      if (len < 6) len = $urandom_range(0, 1);
      else if (len < 86) len = $urandom_range(2, 8);
      else if (len < 98) len = $urandom_range(9, 24);
      else len = $urandom_range(25, 255);
      if (pick < 72) begin
        queue_packet(id, 8'(len), err, $urandom_range(0, 7) == 0, 1'b0, -1);
      end else if (pick < 84) begin
        queue_packet(id, 8'(len), err, 1'b0, 1'b0, $urandom_range(0, len + 3));
        queue_item(ssp_pkg::FUNC_TIMEOUT, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        queue_item(ssp_pkg::FUNC_TIMEOUT, 8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 2) == 0) b = ssp_pkg::SYNC_BYTE;
          queue_item(ssp_pkg::FUNC_BYTE, b);
        end
        queue_item(ssp_pkg::FUNC_TIMEOUT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_accepted != rx_queued || parsed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_expected_id(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    want_id = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver: one transaction per item from rx_stream
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_func <= ssp_pkg::FUNC_BYTE;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        parse_rx_item(cur_item);
        rx_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if ($urandom_range(1, 100) <= idle_odds) begin
          in_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          cur_item = rx_stream.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_item.func;
          in_rx_byte <= cur_item.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t result: expected none, actual kind %0d id %0d byte %0d",
                     $time, out_kind, out_servo_id, out_param_byte);
        end else begin
          want_res = parsed_q.pop_front();
          compare_field("kind", 8'(want_res.kind), 8'(out_kind));
          compare_field("param_index", want_res.param_index, out_param_index);
          compare_field("param_byte", want_res.param_byte, out_param_byte);
          compare_field("servo_id", want_res.servo_id, out_servo_id);
          compare_field("servo_error", want_res.servo_error, out_servo_error);
          compare_field("timeout_flag", 8'(want_res.timeout_flag), 8'(out_timeout_flag));
          compare_field("length_error", 8'(want_res.length_error), 8'(out_length_error));
          compare_field("checksum_error", 8'(want_res.checksum_error),
                        8'(out_checksum_error));
          compare_field("id_mismatch", 8'(want_res.id_mismatch), 8'(out_id_mismatch));
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_odds) begin
        out_gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("servo_status_packet_receiver_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    idle_odds = 20;
    want_id = ssp_pkg::ID_RESET;
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // timeout while hunting
    queue_item(ssp_pkg::FUNC_TIMEOUT, 8'hA5);
    // clean packet with 0x00 / 0xff parameters
    queue_packet(ssp_pkg::ID_RESET, 8'd4, 8'h00, 1'b0, 1'b1, -1);
    // zero length ends after the length byte
    queue_packet(8'h00, 8'd0, 8'h00, 1'b0, 1'b0, -1);
    // length one ends after the error byte
    queue_packet(8'hFF, 8'd1, 8'hFF, 1'b0, 1'b0, -1);
    // timeout before the error byte
    queue_packet(8'h07, 8'd3, 8'h00, 1'b0, 1'b0, 4);
    queue_item(ssp_pkg::FUNC_TIMEOUT, 8'h5A);

    set_expected_id(8'd0);
    idle_odds = 15;
    queue_packet(want_id, 8'd255, 8'h00, 1'b0, 1'b0, -1);
    random_phase(100);

    set_expected_id(ssp_pkg::ID_RESET);
    idle_odds = 40;
    random_phase(360);

    set_expected_id(8'($urandom_range(1, 253)));
    idle_odds = 5;
    random_phase(360);

    set_expected_id(8'($urandom_range(0, 254)));
    idle_odds = 0;
    random_phase(360);

    wait_idle();
    if (errors == 0) begin
      $display("servo_status_packet_receiver_tb: clean");
    end else begin
      $display("servo_status_packet_receiver_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssp_pkg.sv
rtl/ssp_parser.sv
rtl/servo_status_packet_receiver.sv
tb/servo_status_packet_receiver_tb.sv
